/* hdl/ipc_pkg.sv */
// ipc_pkg: shared types and constants for the prefix complement block
// no dependencies; used by every module under hdl
package ipc_pkg;

	localparam int NODE_COUNT  = 65536;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int CNT_W       = NODE_W + 1;
	localparam int ADDR_BITS   = 32;
	localparam int LEN_W       = $clog2(ADDR_BITS + 1);
	localparam int STACK_DEPTH = ADDR_BITS + 1;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SI_W        = $clog2(STACK_DEPTH);
	localparam int TDATA_W     = ((ADDR_BITS + LEN_W + 7) / 8) * 8;
	localparam int PAD_W       = TDATA_W - ADDR_BITS - LEN_W;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_FETCH  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_IWALK,
		ST_ALLOC,
		ST_ROOT,
		ST_CHILD,
		ST_COV,
		ST_ADV,
		ST_POP,
		ST_FIN
	} state_t;

	typedef struct packed {
		mode_t                  mode;
		logic [ADDR_BITS-1:0]   addr;
		logic [LEN_W-1:0]       len;
	} item_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]   addr;
		logic [LEN_W-1:0]       len;
		logic                   valid;
		logic                   last;
		logic                   status;
	} res_t;

	typedef struct packed {
		logic                   cov;
		logic [NODE_W-1:0]      c1;
		logic [NODE_W-1:0]      c0;
	} node_ent_t;

	typedef struct packed {
		logic                   c0_en;
		logic                   c1_en;
		logic                   cov_en;
		logic [NODE_W-1:0]      addr;
		node_ent_t              data;
	} nram_wr_t;

	typedef struct packed {
		logic                   ready;
		logic                   done;
	} seq_ctl_t;

endpackage

/* hdl/ipc_node_ram.sv */
// ipc_node_ram: trie node table, child links and covered flags
// one write port with per-field enables, one registered read port; uses ipc_pkg
module ipc_node_ram (
	input  logic                      clk,
	input  ipc_pkg::nram_wr_t         wr,
	input  logic                      rd_en,
	input  logic [ipc_pkg::NODE_W-1:0] rd_addr,
	output ipc_pkg::node_ent_t        rd_data
);

	logic [ipc_pkg::NODE_W-1:0] c0_mem  [ipc_pkg::NODE_COUNT];
	logic [ipc_pkg::NODE_W-1:0] c1_mem  [ipc_pkg::NODE_COUNT];
	logic                       cov_mem [ipc_pkg::NODE_COUNT];
	ipc_pkg::node_ent_t         rd_q;

	always_ff @(posedge clk) begin
		if (wr.c0_en) begin
			c0_mem[wr.addr] <= wr.data.c0;
		end
		if (wr.c1_en) begin
			c1_mem[wr.addr] <= wr.data.c1;
		end
		if (wr.cov_en) begin
			cov_mem[wr.addr] <= wr.data.cov;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q.c0  <= c0_mem[rd_addr];
			rd_q.c1  <= c1_mem[rd_addr];
			rd_q.cov <= cov_mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* hdl/ipc_frame_stack.sv */
// ipc_frame_stack: node ids of the depth-first walk frames
// one write port, one registered read port; uses ipc_pkg
module ipc_frame_stack (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ipc_pkg::SI_W-1:0]    wr_addr,
	input  logic [ipc_pkg::NODE_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [ipc_pkg::SI_W-1:0]    rd_addr,
	output logic [ipc_pkg::NODE_W-1:0]  rd_data
);

	logic [ipc_pkg::NODE_W-1:0] mem [ipc_pkg::STACK_DEPTH];
	logic [ipc_pkg::NODE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* hdl/ipc_seq.sv */
// ipc_seq: sequencer for insert, clear and complement walk over the node table
// drives ipc_node_ram and ipc_frame_stack ports; uses ipc_pkg
module ipc_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  ipc_pkg::item_t              item,
	input  logic                        out_free,
	output ipc_pkg::seq_ctl_t           ctl,
	output ipc_pkg::res_t               res,
	output ipc_pkg::nram_wr_t           nram_wr,
	output logic                        nram_rd_en,
	output logic [ipc_pkg::NODE_W-1:0]  nram_rd_addr,
	input  ipc_pkg::node_ent_t          nram_rd_data,
	output logic                        stk_wr_en,
	output logic [ipc_pkg::SI_W-1:0]    stk_wr_addr,
	output logic [ipc_pkg::NODE_W-1:0]  stk_wr_data,
	output logic                        stk_rd_en,
	output logic [ipc_pkg::SI_W-1:0]    stk_rd_addr,
	input  logic [ipc_pkg::NODE_W-1:0]  stk_rd_data
);

	ipc_pkg::state_t                   state_q, state_d;
	logic [ipc_pkg::ADDR_BITS-1:0]     addr_q, addr_d;
	logic [ipc_pkg::LEN_W-1:0]         len_q, len_d;
	logic [ipc_pkg::NODE_W-1:0]        node_q, node_d;
	logic [ipc_pkg::LEN_W-1:0]         level_q, level_d;
	logic [ipc_pkg::CNT_W-1:0]         used_q, used_d;
	logic                              any_q, any_d;
	logic                              started_q, started_d;
	logic [ipc_pkg::SP_W-1:0]          depth_q, depth_d;
	logic [ipc_pkg::STACK_DEPTH-1:0]   ph_q, ph_d;
	logic [ipc_pkg::NODE_W-1:0]        cur_q, cur_d;
	logic [ipc_pkg::NODE_W-1:0]        cand_q, cand_d;
	ipc_pkg::res_t                     res_q, res_d;

	logic [ipc_pkg::ADDR_BITS-1:0]     shl;
	logic                              ins_bit;
	logic                              alloc_bit;
	logic [ipc_pkg::NODE_W-1:0]        ins_c;
	logic [ipc_pkg::LEN_W-1:0]         need;
	logic [ipc_pkg::CNT_W:0]           used_sum;
	logic                              full;
	logic [ipc_pkg::NODE_W-1:0]        fresh;
	logic                              last_lvl;
	logic [ipc_pkg::SP_W-1:0]          top;
	logic                              ph_top;
	logic [ipc_pkg::NODE_W-1:0]        walk_c;
	logic [ipc_pkg::ADDR_BITS-1:0]     emit_addr;
	logic [ipc_pkg::LEN_W-1:0]         len_clamp;

	// frame below the top: depth minus two
	function automatic logic [ipc_pkg::SI_W-1:0] SI_SEL(input logic [ipc_pkg::SP_W-1:0] d);
		logic [ipc_pkg::SP_W-1:0] t;
		t = d - ipc_pkg::SP_W'(2);
		return t[ipc_pkg::SI_W-1:0];
	endfunction

	assign shl      = addr_q << level_q;
	assign ins_bit  = shl[ipc_pkg::ADDR_BITS-1];
	// branch bit below the node being allocated
	assign alloc_bit = shl[ipc_pkg::ADDR_BITS-2];
	assign ins_c    = ins_bit ? nram_rd_data.c1 : nram_rd_data.c0;
	assign need     = len_q - level_q;
	assign used_sum = {1'b0, used_q} + (ipc_pkg::CNT_W + 1)'(need);
	assign full     = used_sum > (ipc_pkg::CNT_W + 1)'(ipc_pkg::NODE_COUNT);
	assign fresh    = used_q[ipc_pkg::NODE_W-1:0];
	assign last_lvl = (level_q + 1'b1) == len_q;
	assign top      = depth_q - 1'b1;
	assign ph_top   = ph_q[top[ipc_pkg::SI_W-1:0]];
	assign walk_c   = ph_top ? nram_rd_data.c1 : nram_rd_data.c0;
	assign len_clamp = (item.len > ipc_pkg::LEN_W'(ipc_pkg::ADDR_BITS)) ?
		ipc_pkg::LEN_W'(ipc_pkg::ADDR_BITS) : item.len;

	always_comb begin
		for (int k = 0; k < ipc_pkg::ADDR_BITS; k++) begin
			emit_addr[ipc_pkg::ADDR_BITS-1-k] = ph_q[k] & (ipc_pkg::SP_W'(k) < depth_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ipc_pkg::ST_INIT;
			used_q    <= ipc_pkg::CNT_W'(1);
			any_q     <= 1'b0;
			started_q <= 1'b0;
			depth_q   <= '0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			any_q     <= any_d;
			started_q <= started_d;
			depth_q   <= depth_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		len_q   <= len_d;
		node_q  <= node_d;
		level_q <= level_d;
		ph_q    <= ph_d;
		cur_q   <= cur_d;
		cand_q  <= cand_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d      = state_q;
		addr_d       = addr_q;
		len_d        = len_q;
		node_d       = node_q;
		level_d      = level_q;
		used_d       = used_q;
		any_d        = any_q;
		started_d    = started_q;
		depth_d      = depth_q;
		ph_d         = ph_q;
		cur_d        = cur_q;
		cand_d       = cand_q;
		res_d        = res_q;
		nram_wr      = '0;
		nram_rd_en   = 1'b0;
		nram_rd_addr = '0;
		stk_wr_en    = 1'b0;
		stk_wr_addr  = '0;
		stk_wr_data  = '0;
		stk_rd_en    = 1'b0;
		stk_rd_addr  = '0;
		ctl.done     = 1'b0;
		ctl.ready    = (state_q == ipc_pkg::ST_IDLE);

		case (state_q)
			ipc_pkg::ST_INIT: begin
				nram_wr.c0_en  = 1'b1;
				nram_wr.c1_en  = 1'b1;
				nram_wr.cov_en = 1'b1;
				state_d        = ipc_pkg::ST_IDLE;
			end
			ipc_pkg::ST_IDLE: begin
				if (start) begin
					res_d   = '0;
					state_d = ipc_pkg::ST_FIN;
					case (item.mode)
						ipc_pkg::MODE_CLEAR: begin
							used_d         = ipc_pkg::CNT_W'(1);
							any_d          = 1'b0;
							started_d      = 1'b0;
							depth_d        = '0;
							nram_wr.c0_en  = 1'b1;
							nram_wr.c1_en  = 1'b1;
							nram_wr.cov_en = 1'b1;
						end
						ipc_pkg::MODE_INSERT: begin
							addr_d     = item.addr;
							len_d      = len_clamp;
							node_d     = '0;
							level_d    = '0;
							nram_rd_en = 1'b1;
							state_d    = ipc_pkg::ST_IWALK;
						end
						ipc_pkg::MODE_FETCH: begin
							if (!started_q) begin
								started_d = 1'b1;
								depth_d   = '0;
								if (!any_q) begin
									res_d.valid = 1'b1;
								end else begin
									nram_rd_en = 1'b1;
									state_d    = ipc_pkg::ST_ROOT;
								end
							end else if (depth_q == '0) begin
								res_d.last = 1'b1;
							end else begin
								nram_rd_en   = 1'b1;
								nram_rd_addr = cur_q;
								state_d      = ipc_pkg::ST_CHILD;
							end
						end
						default: begin
							state_d = ipc_pkg::ST_FIN;
						end
					endcase
				end
			end
			ipc_pkg::ST_IWALK: begin
				if ((level_q < len_q) && (ins_c != '0)) begin
					node_d       = ins_c;
					level_d      = level_q + 1'b1;
					nram_rd_en   = 1'b1;
					nram_rd_addr = ins_c;
				end else if (full) begin
					res_d.status = 1'b1;
					state_d      = ipc_pkg::ST_FIN;
				end else begin
					any_d        = 1'b1;
					started_d    = 1'b0;
					depth_d      = '0;
					nram_wr.addr = node_q;
					if (level_q == len_q) begin
						nram_wr.cov_en   = 1'b1;
						nram_wr.data.cov = 1'b1;
						state_d          = ipc_pkg::ST_FIN;
					end else begin
						if (ins_bit) begin
							nram_wr.c1_en   = 1'b1;
							nram_wr.data.c1 = fresh;
						end else begin
							nram_wr.c0_en   = 1'b1;
							nram_wr.data.c0 = fresh;
						end
						state_d = ipc_pkg::ST_ALLOC;
					end
				end
			end
			ipc_pkg::ST_ALLOC: begin
				nram_wr.c0_en    = 1'b1;
				nram_wr.c1_en    = 1'b1;
				nram_wr.cov_en   = 1'b1;
				nram_wr.addr     = fresh;
				nram_wr.data.cov = last_lvl;
				nram_wr.data.c0  = (!last_lvl && !alloc_bit) ? fresh + 1'b1 : '0;
				nram_wr.data.c1  = (!last_lvl && alloc_bit) ? fresh + 1'b1 : '0;
				used_d           = used_q + 1'b1;
				level_d          = level_q + 1'b1;
				if (last_lvl) begin
					state_d = ipc_pkg::ST_FIN;
				end
			end
			ipc_pkg::ST_ROOT: begin
				if (!nram_rd_data.cov) begin
					stk_wr_en = 1'b1;
					ph_d[0]   = 1'b0;
					depth_d   = ipc_pkg::SP_W'(1);
					cur_d     = '0;
					state_d   = ipc_pkg::ST_CHILD;
				end else begin
					res_d.last = 1'b1;
					state_d    = ipc_pkg::ST_FIN;
				end
			end
			ipc_pkg::ST_CHILD: begin
				if (depth_q > ipc_pkg::SP_W'(ipc_pkg::ADDR_BITS)) begin
					ph_d[top[ipc_pkg::SI_W-1:0]] = 1'b1;
					state_d = ipc_pkg::ST_ADV;
				end else if (walk_c != '0) begin
					cand_d       = walk_c;
					nram_rd_en   = 1'b1;
					nram_rd_addr = walk_c;
					state_d      = ipc_pkg::ST_COV;
				end else begin
					res_d.valid = 1'b1;
					res_d.addr  = emit_addr;
					res_d.len   = depth_q;
					state_d     = ipc_pkg::ST_ADV;
				end
			end
			ipc_pkg::ST_COV: begin
				if (nram_rd_data.cov) begin
					state_d = ipc_pkg::ST_ADV;
				end else begin
					stk_wr_en   = 1'b1;
					stk_wr_addr = depth_q[ipc_pkg::SI_W-1:0];
					stk_wr_data = cand_q;
					ph_d[depth_q[ipc_pkg::SI_W-1:0]] = 1'b0;
					depth_d     = depth_q + 1'b1;
					cur_d       = cand_q;
					state_d     = ipc_pkg::ST_CHILD;
				end
			end
			ipc_pkg::ST_ADV: begin
				if (depth_q == '0) begin
					res_d.last = !res_q.valid;
					state_d    = ipc_pkg::ST_FIN;
				end else if (!ph_top) begin
					ph_d[top[ipc_pkg::SI_W-1:0]] = 1'b1;
					if (res_q.valid) begin
						state_d = ipc_pkg::ST_FIN;
					end else begin
						nram_rd_en   = 1'b1;
						nram_rd_addr = cur_q;
						state_d      = ipc_pkg::ST_CHILD;
					end
				end else begin
					depth_d = top;
					if (depth_q >= ipc_pkg::SP_W'(2)) begin
						stk_rd_en   = 1'b1;
						stk_rd_addr = SI_SEL(depth_q);
						state_d     = ipc_pkg::ST_POP;
					end
				end
			end
			ipc_pkg::ST_POP: begin
				cur_d   = stk_rd_data;
				state_d = ipc_pkg::ST_ADV;
			end
			ipc_pkg::ST_FIN: begin
				if (out_free) begin
					ctl.done = 1'b1;
					state_d  = ipc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ipc_pkg::ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= ipc_pkg::SP_W'(ipc_pkg::STACK_DEPTH))
		else $error("walk depth beyond stack");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != '0) && (used_q <= ipc_pkg::CNT_W'(ipc_pkg::NODE_COUNT)))
		else $error("node count out of range");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ipc_pkg::ST_ALLOC) |-> (used_q < ipc_pkg::CNT_W'(ipc_pkg::NODE_COUNT)))
		else $error("allocation past end of node table");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ipc_pkg::ST_FIN && res_q.valid) |-> (!res_q.last && !res_q.status))
		else $error("valid result also flagged last or refused");

	a_pop_then_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ipc_pkg::ST_POP) |=> (state_q == ipc_pkg::ST_ADV))
		else $error("pop not followed by advance");

endmodule

/* hdl/ip_prefix_set_complement.sv */
// ip_prefix_set_complement: top level, stream ports and output register
// instantiates ipc_seq, ipc_node_ram and ipc_frame_stack; uses ipc_pkg
// a clear or a finished walk goes straight to ST_FIN; an insert steps through ST_IWALK and ST_ALLOC,
// a fetch through ST_ROOT, ST_CHILD, ST_COV, ST_ADV and ST_POP; ST_FIN waits for the output register
// throughput: one beat at a time; the single read port of the node table sets the pace
// one result beat per input beat, held in an output register until taken
// reset: async, writes the root node in ST_INIT, then ready; table otherwise undefined
module ip_prefix_set_complement (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [ipc_pkg::TDATA_W-1:0]  s_axis_tdata,  // prefix_addr, prefix_len, zero pad
	input  logic [1:0]                   s_axis_tuser,  // mode
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ipc_pkg::TDATA_W-1:0]  m_axis_tdata,  // out_addr, out_len, zero pad
	output logic [1:0]                   m_axis_tuser,  // out_valid, status
	output logic                         m_axis_tlast
);

	ipc_pkg::item_t                 item;
	ipc_pkg::seq_ctl_t              ctl;
	ipc_pkg::res_t                  res;
	ipc_pkg::res_t                  out_q;
	logic                           m_valid_q;
	logic                           out_free;
	ipc_pkg::nram_wr_t              nram_wr;
	logic                           nram_rd_en;
	logic [ipc_pkg::NODE_W-1:0]     nram_rd_addr;
	ipc_pkg::node_ent_t             nram_rd_data;
	logic                           stk_wr_en;
	logic [ipc_pkg::SI_W-1:0]       stk_wr_addr;
	logic [ipc_pkg::NODE_W-1:0]     stk_wr_data;
	logic                           stk_rd_en;
	logic [ipc_pkg::SI_W-1:0]       stk_rd_addr;
	logic [ipc_pkg::NODE_W-1:0]     stk_rd_data;

	assign item.mode = ipc_pkg::mode_t'(s_axis_tuser);
	assign item.addr = s_axis_tdata[ipc_pkg::ADDR_BITS-1:0];
	assign item.len  = s_axis_tdata[ipc_pkg::ADDR_BITS +: ipc_pkg::LEN_W];

	assign s_axis_tready = ctl.ready;
	assign out_free      = !m_valid_q || m_axis_tready;

	ipc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (s_axis_tvalid && ctl.ready),
		.item         (item),
		.out_free     (out_free),
		.ctl          (ctl),
		.res          (res),
		.nram_wr      (nram_wr),
		.nram_rd_en   (nram_rd_en),
		.nram_rd_addr (nram_rd_addr),
		.nram_rd_data (nram_rd_data),
		.stk_wr_en    (stk_wr_en),
		.stk_wr_addr  (stk_wr_addr),
		.stk_wr_data  (stk_wr_data),
		.stk_rd_en    (stk_rd_en),
		.stk_rd_addr  (stk_rd_addr),
		.stk_rd_data  (stk_rd_data)
	);

	ipc_node_ram u_node_ram (
		.clk     (clk),
		.wr      (nram_wr),
		.rd_en   (nram_rd_en),
		.rd_addr (nram_rd_addr),
		.rd_data (nram_rd_data)
	);

	ipc_frame_stack u_frame_stack (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {ipc_pkg::PAD_W'(0), out_q.len, out_q.addr};
	assign m_axis_tuser  = {out_q.status, out_q.valid};
	assign m_axis_tlast  = out_q.last;

endmodule

/* verif/tb_ip_prefix_set_complement.sv */
// tb_ip_prefix_set_complement: self-checking testbench for the prefix complement block
// keeps its own trie predictor, drives random stream traffic with stalls on both sides
// depends on ipc_pkg and ip_prefix_set_complement from hdl
`timescale 1ns / 1ps

module tb_ip_prefix_set_complement;

	localparam logic [1:0] MODE_NOP     = 2'd3;
	localparam int         RANDOM_ITEMS = 1900;
	localparam int         CYCLE_LIMIT  = 4000000;
	localparam int         TAIL_CYCLES  = 400;

	logic                          clk;
	logic                          arst_n        = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [ipc_pkg::TDATA_W-1:0]   s_axis_tdata  = '0;
	logic [1:0]                    s_axis_tuser  = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [ipc_pkg::TDATA_W-1:0]   m_axis_tdata;
	logic [1:0]                    m_axis_tuser;
	logic                          m_axis_tlast;

	ip_prefix_set_complement uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// trie predictor state
	int unsigned kid0 [ipc_pkg::NODE_COUNT];
	int unsigned kid1 [ipc_pkg::NODE_COUNT];
	bit          is_cov [ipc_pkg::NODE_COUNT];
	int unsigned used_nodes;
	bit          have_prefix;
	int unsigned path_stk [ipc_pkg::STACK_DEPTH];
	int unsigned path_top;
	bit          walk_live;

	ipc_pkg::res_t pending_res [$];
	int          mismatch_count;
	int          items_sent;
	int          inserts_ok, inserts_refused, prefixes_out, walk_ends, clears_sent;
	int          cycle_count;
	bit          tx_gaps_on = 1'b1;
	bit          rx_gaps_on = 1'b1;
	int          rx_hold;

	function automatic void trie_clear();
		used_nodes  = 1;
		kid0[0]     = 0;
		kid1[0]     = 0;
		is_cov[0]   = 1'b0;
		have_prefix = 1'b0;
		path_top    = 0;
		walk_live   = 1'b0;
	endfunction

	function automatic logic trie_insert(logic [ipc_pkg::ADDR_BITS-1:0] a,
			logic [ipc_pkg::LEN_W-1:0] l);
		int unsigned node, lvl, plen, nxt, fresh;
		plen = (l > ipc_pkg::ADDR_BITS) ? ipc_pkg::ADDR_BITS : l;
		node = 0;
		lvl  = 0;
		while (lvl < plen) begin
			nxt = a[ipc_pkg::ADDR_BITS-1-lvl] ? kid1[node] : kid0[node];
			if (nxt == 0)
				break;
			node = nxt;
			lvl++;
		end
		if (used_nodes + (plen - lvl) > ipc_pkg::NODE_COUNT)
			return 1'b1;
		while (lvl < plen) begin
			fresh = used_nodes;
			used_nodes++;
			kid0[fresh]   = 0;
			kid1[fresh]   = 0;
			is_cov[fresh] = 1'b0;
			if (a[ipc_pkg::ADDR_BITS-1-lvl])
				kid1[node] = fresh;
			else
				kid0[node] = fresh;
			node = fresh;
			lvl++;
		end
		is_cov[node] = 1'b1;
		have_prefix  = 1'b1;
		path_top     = 0;
		walk_live    = 1'b0;
		return 1'b0;
	endfunction

	// step past the current child of the top frame, dropping finished frames
	function automatic void walk_advance();
		while (path_top > 0) begin
			if (path_stk[path_top-1][0] == 1'b0) begin
				path_stk[path_top-1][0] = 1'b1;
				return;
			end
			path_top--;
		end
	endfunction

	function automatic ipc_pkg::res_t trie_fetch();
		ipc_pkg::res_t                 r;
		int unsigned                   frame, node, kid, k;
		logic [ipc_pkg::ADDR_BITS-1:0] a;
		r = '0;
		if (!walk_live) begin
			walk_live = 1'b1;
			path_top  = 0;
			if (!have_prefix) begin
				r.valid = 1'b1;
				return r;
			end
			if (!is_cov[0]) begin
				path_stk[0] = 0;
				path_top    = 1;
			end
		end
		while (path_top > 0) begin
			frame = path_stk[path_top-1];
			node  = frame >> 1;
			kid   = frame[0] ? kid1[node] : kid0[node];
			if (path_top > ipc_pkg::ADDR_BITS) begin
				path_top--;
				walk_advance();
			end else if (kid != 0) begin
				if (is_cov[kid])
					walk_advance();
				else begin
					path_stk[path_top] = kid << 1;
					path_top++;
				end
			end else begin
				a = '0;
				for (k = 0; k < path_top; k++)
					a[ipc_pkg::ADDR_BITS-1-k] = path_stk[k][0];
				r.addr  = a;
				r.len   = ipc_pkg::LEN_W'(path_top);
				r.valid = 1'b1;
				walk_advance();
				return r;
			end
		end
		r.last = 1'b1;
		return r;
	endfunction

	function automatic ipc_pkg::res_t predict_item(logic [1:0] mode,
			logic [ipc_pkg::ADDR_BITS-1:0] a, logic [ipc_pkg::LEN_W-1:0] l);
		ipc_pkg::res_t r;
		r = '0;
		case (mode)
			ipc_pkg::MODE_CLEAR:  trie_clear();
			ipc_pkg::MODE_INSERT: r.status = trie_insert(a, l);
			ipc_pkg::MODE_FETCH:  r = trie_fetch();
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ipc_pkg::LEN_W-1:0] rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return ipc_pkg::LEN_W'($urandom_range(0, 12));
		if (r < 90)
			return ipc_pkg::LEN_W'($urandom_range(13, 32));
		return ipc_pkg::LEN_W'($urandom_range(33, 63));
	endfunction

	task automatic note_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// one input beat; returns the predicted result of that beat
	task automatic send_item(input logic [1:0] mode, input logic [ipc_pkg::ADDR_BITS-1:0] a,
			input logic [ipc_pkg::LEN_W-1:0] l, output ipc_pkg::res_t want);
		int gap;
		gap = pick_gap(tx_gaps_on);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{ipc_pkg::PAD_W{1'b0}}, l, a};
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		want = predict_item(mode, a, l);
		pending_res = {pending_res, want};
		if (mode != MODE_NOP)
			items_sent++;
		if (mode == ipc_pkg::MODE_CLEAR)
			clears_sent++;
		if (mode == ipc_pkg::MODE_INSERT) begin
			if (want.status)
				inserts_refused++;
			else
				inserts_ok++;
		end
		if (want.valid)
			prefixes_out++;
		if (want.last)
			walk_ends++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	task automatic insert_random(input logic [ipc_pkg::ADDR_BITS-1:0] base);
		ipc_pkg::res_t                 want;
		logic [ipc_pkg::ADDR_BITS-1:0] a;
		a = $urandom;
		if ($urandom_range(0, 1))
			a = base ^ (a & ((32'h1 << $urandom_range(4, 20)) - 1));
		send_item(ipc_pkg::MODE_INSERT, a, rand_len(), want);
	endtask

	task automatic test_empty_set();
		ipc_pkg::res_t want;
		send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_FETCH, 32'hFFFFFFFF, 6'd63, want);
		send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(MODE_NOP, 32'hFFFFFFFF, 6'd63, want);
		send_item(ipc_pkg::MODE_CLEAR, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		drain_results();
	endtask

	task automatic test_directed_prefixes();
		ipc_pkg::res_t want;
		send_item(ipc_pkg::MODE_INSERT, 32'h0, 6'd1, want);
		repeat (3) send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_INSERT, 32'hFFFFFFFF, 6'd63, want);
		repeat (3) send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(MODE_NOP, 32'h12345678, 6'd5, want);
		send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_INSERT, 32'hAAAA5555, 6'd40, want);
		repeat (2) send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_INSERT, 32'h0A010203, 6'd8, want);
		send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_INSERT, 32'h55555555, 6'd0, want);
		repeat (2) send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		send_item(ipc_pkg::MODE_CLEAR, 32'hFFFFFFFF, 6'd32, want);
		send_item(ipc_pkg::MODE_FETCH, 32'h0, 6'd0, want);
		drain_results();
	endtask

	task automatic test_random_walks();
		ipc_pkg::res_t                 want;
		logic [ipc_pkg::ADDR_BITS-1:0] base;
		int                            start, n, cap, tail, f, r;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			tx_gaps_on = ($urandom_range(0, 4) != 0);
			rx_gaps_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 7)
				send_item(ipc_pkg::MODE_CLEAR, $urandom, ipc_pkg::LEN_W'($urandom), want);
			base = $urandom;
			n = $urandom_range(1, 8);
			repeat (n) insert_random(base);
			cap  = $urandom_range(10, 120);
			tail = $urandom_range(1, 3);
			for (f = 0; f < cap && tail > 0; f++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_item(MODE_NOP, $urandom, ipc_pkg::LEN_W'($urandom), want);
				else if (r < 7)
					insert_random(base);
				else if (r < 8)
					send_item(ipc_pkg::MODE_CLEAR, $urandom, ipc_pkg::LEN_W'($urandom),
						want);
				else begin
					send_item(ipc_pkg::MODE_FETCH, $urandom, ipc_pkg::LEN_W'($urandom),
						want);
					if (want.last)
						tail--;
				end
			end
			// hold the sender until everything in flight has come back
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		drain_results();
	endtask

	always @(posedge clk) begin : result_check
		ipc_pkg::res_t                 want;
		logic [ipc_pkg::ADDR_BITS-1:0] got_addr;
		logic [ipc_pkg::LEN_W-1:0]     got_len;
		logic [ipc_pkg::PAD_W-1:0]     got_pad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_addr = m_axis_tdata[ipc_pkg::ADDR_BITS-1:0];
			got_len  = m_axis_tdata[ipc_pkg::ADDR_BITS +: ipc_pkg::LEN_W];
			got_pad  = m_axis_tdata[ipc_pkg::TDATA_W-1 -: ipc_pkg::PAD_W];
			if (pending_res.size() == 0)
				note_mismatch("beat with nothing expected", 64'(m_axis_tdata), '0);
			else begin
				want = pending_res.pop_front();
				if (got_addr !== want.addr)
					note_mismatch("out_addr", 64'(got_addr), 64'(want.addr));
				if (got_len !== want.len)
					note_mismatch("out_len", 64'(got_len), 64'(want.len));
				if (m_axis_tuser[0] !== want.valid)
					note_mismatch("out_valid", 64'(m_axis_tuser[0]), 64'(want.valid));
				if (m_axis_tlast !== want.last)
					note_mismatch("out_last", 64'(m_axis_tlast), 64'(want.last));
				if (m_axis_tuser[1] !== want.status)
					note_mismatch("status", 64'(m_axis_tuser[1]), 64'(want.status));
				if (got_pad !== '0)
					note_mismatch("tdata pad", 64'(got_pad), '0);
			end
		end
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_axis_tready <= 1'b1;
			rx_hold = pick_gap(rx_gaps_on);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_res.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		trie_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_set();
		test_directed_prefixes();
		test_random_walks();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d beats: %0d inserts taken, %0d refused, %0d clears", items_sent,
			inserts_ok, inserts_refused, clears_sent);
		$display("fetches gave %0d prefixes and %0d end-of-walk answers, %0d mismatches",
			prefixes_out, walk_ends, mismatch_count);
		if (mismatch_count == 0 && pending_res.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* ip_prefix_set_complement.f */
hdl/ipc_pkg.sv
hdl/ipc_node_ram.sv
hdl/ipc_frame_stack.sv
hdl/ipc_seq.sv
hdl/ip_prefix_set_complement.sv
verif/tb_ip_prefix_set_complement.sv
